>>> design/dtda_pkg.sv
// Shared types, constants and the month-length function of the date-time duration adder.
// Used by dtda_ctrl, dtda_dpath and the top level; depends on nothing.
package dtda_pkg;

	typedef enum logic [2:0] {
		DIV_MON  = 3'd0,
		DIV_YEAR = 3'd1,
		DIV_S60  = 3'd2,
		DIV_M60  = 3'd3,
		DIV_H24  = 3'd4
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     mon_step;
		logic     nano_step;
		logic     clock_step;
		logic     walk_step;
	} dtda_cmd_t;

	typedef struct packed {
		logic div_run;
		logic div_done;
		logic sat;
		logic walk_ok;
	} dtda_stat_t;

	localparam logic [1:0] RS_NORMAL = 2'd0;
	localparam logic [1:0] RS_FUTURE = 2'd1;
	localparam logic [1:0] RS_PAST   = 2'd2;

	localparam logic signed [32:0] NS_PER_S   = 33'sd1000000000;
	localparam logic signed [32:0] NS_TWO_S   = 33'sd2000000000;
	localparam logic signed [33:0] YEAR_MAX   = 34'sd32767;
	localparam logic signed [33:0] YEAR_MIN   = -34'sd32768;
	localparam logic signed [15:0] YEAR_MAX16 = 16'sh7FFF;
	localparam logic signed [15:0] YEAR_MIN16 = 16'sh8000;

	localparam logic [8:0] DIVISOR_MON  = 9'd12;
	localparam logic [8:0] DIVISOR_YEAR = 9'd400;
	localparam logic [8:0] DIVISOR_60   = 9'd60;
	localparam logic [8:0] DIVISOR_24   = 9'd24;

	// Reciprocals floor(2^32 / d) of the divisors above.
	localparam logic [31:0] RECIP_MON  = 32'd357913941;
	localparam logic [31:0] RECIP_YEAR = 32'd10737418;
	localparam logic [31:0] RECIP_60   = 32'd71582788;
	localparam logic [31:0] RECIP_24   = 32'd178956970;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m) inside
			MONTH_FEB: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

>>> design/dtda_ctrl.sv
// Sequencer of the date-time duration adder: one-hot state machine that issues
// commands to dtda_dpath and follows its status. Depends on dtda_pkg.
module dtda_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dtda_pkg::dtda_stat_t  stat,
	output dtda_pkg::dtda_cmd_t   cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DMON  = 11'b000_0000_0010,
		S_MSTEP = 11'b000_0000_0100,
		S_DYEAR = 11'b000_0000_1000,
		S_DS60  = 11'b000_0001_0000,
		S_DM60  = 11'b000_0010_0000,
		S_DH24  = 11'b000_0100_0000,
		S_NSTEP = 11'b000_1000_0000,
		S_CSTEP = 11'b001_0000_0000,
		S_WALK  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.div_sel    = dtda_pkg::DIV_MON;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DMON;
				end
			end
			S_DMON: begin
				cmd.div_sel   = dtda_pkg::DIV_MON;
				cmd.div_start = !stat.div_run;
				if (stat.div_done) state_d = S_MSTEP;
			end
			S_MSTEP: begin
				cmd.mon_step = 1'b1;
				state_d      = S_DYEAR;
			end
			S_DYEAR: begin
				// A year overflow from the month step ends the transaction here.
				cmd.div_sel   = dtda_pkg::DIV_YEAR;
				cmd.div_start = !stat.div_run && !stat.sat;
				if (stat.sat) state_d = S_DONE;
				else if (stat.div_done) state_d = S_DS60;
			end
			S_DS60: begin
				cmd.div_sel   = dtda_pkg::DIV_S60;
				cmd.div_start = !stat.div_run;
				if (stat.div_done) state_d = S_DM60;
			end
			S_DM60: begin
				cmd.div_sel   = dtda_pkg::DIV_M60;
				cmd.div_start = !stat.div_run;
				if (stat.div_done) state_d = S_DH24;
			end
			S_DH24: begin
				cmd.div_sel   = dtda_pkg::DIV_H24;
				cmd.div_start = !stat.div_run;
				if (stat.div_done) state_d = S_NSTEP;
			end
			S_NSTEP: begin
				cmd.nano_step = 1'b1;
				state_d       = S_CSTEP;
			end
			S_CSTEP: begin
				cmd.clock_step = 1'b1;
				state_d        = S_WALK;
			end
			S_WALK: begin
				if (stat.sat || stat.walk_ok) state_d = S_DONE;
				else cmd.walk_step = 1'b1;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

>>> design/dtda_dpath.sv
// Datapath of the date-time duration adder: operand registers, a shared divider by small
// constants built on reciprocal multiplication, carry steps and the month walk.
// Depends on dtda_pkg.
module dtda_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtda_pkg::dtda_cmd_t  cmd,
	output dtda_pkg::dtda_stat_t stat,
	input  logic signed [15:0]   start_year,
	input  logic [3:0]           start_month,
	input  logic [4:0]           start_day,
	input  logic                 start_utc,
	input  logic [4:0]           start_hour,
	input  logic [5:0]           start_minute,
	input  logic [5:0]           start_second,
	input  logic [29:0]          start_nanosecond,
	input  logic signed [31:0]   add_months,
	input  logic signed [31:0]   add_seconds,
	input  logic signed [30:0]   add_nanoseconds,
	output logic signed [15:0]   end_year,
	output logic [7:0]           end_month,
	output logic [7:0]           end_day,
	output logic                 end_utc,
	output logic [7:0]           end_hour,
	output logic [7:0]           end_minute,
	output logic [7:0]           end_second,
	output logic [31:0]          end_nanosecond,
	output logic [1:0]           range_status
);

	logic signed [15:0] year_q;
	logic [3:0]         month_q;
	logic signed [17:0] day_q;
	logic               utc_q;
	logic [4:0]         hour_q;
	logic [5:0]         minute_q;
	logic [5:0]         second_q;
	logic [29:0]        nano_q;
	logic signed [31:0] dmon_q;
	logic signed [31:0] dsec_q;
	logic signed [30:0] dnano_q;
	logic [1:0]         sat_q;

	logic [31:0]        mq_q;
	logic [3:0]         mr_q;
	logic [8:0]         ymod_q;
	logic [5:0]         sr_q;
	logic [5:0]         minr_q;
	logic [4:0]         hr_q;
	logic [14:0]        days_q;
	logic signed [2:0]  nc_q;

	// Divider: the high word of x times floor(2^32 / d) is the quotient or one below it,
	// so one compare and subtract finishes it.
	logic [31:0]          dvd_q;
	logic [8:0]           dvs_q;
	logic [31:0]          recip_q;
	logic [63:0]          prod_q;
	logic [31:0]          quo_q;
	logic [9:0]           rem_q;
	logic [1:0]           cnt_q;
	logic                 div_run_q;
	dtda_pkg::div_sel_t   sel_q;
	logic [31:0]          qd;
	logic [31:0]          rem_wide;
	logic                 fix;
	logic [8:0]           rem_nx;
	logic [31:0]          quo_nx;
	logic [31:0]          op;
	logic [8:0]           dvs;
	logic [31:0]          recip;
	logic [31:0]          dmon_mag;
	logic [31:0]          dsec_mag;
	logic [15:0]          year_mag;
	logic                 div_last;

	assign dmon_mag = dmon_q[31] ? (~dmon_q + 32'd1) : dmon_q;
	assign dsec_mag = dsec_q[31] ? (~dsec_q + 32'd1) : dsec_q;
	assign year_mag = year_q[15] ? (~year_q + 16'd1) : year_q;

	assign qd       = prod_q[63:32] * {23'd0, dvs_q};
	assign rem_wide = dvd_q - qd;
	assign fix      = (rem_q >= {1'b0, dvs_q});
	assign quo_nx   = fix ? (quo_q + 32'd1) : quo_q;
	assign rem_nx   = fix ? 9'(rem_q - {1'b0, dvs_q}) : rem_q[8:0];
	assign div_last = div_run_q && (cnt_q == 2'd2);

	always_comb begin
		case (cmd.div_sel)
			dtda_pkg::DIV_MON: begin
				op    = dmon_mag;
				dvs   = dtda_pkg::DIVISOR_MON;
				recip = dtda_pkg::RECIP_MON;
			end
			dtda_pkg::DIV_YEAR: begin
				op    = {16'd0, year_mag};
				dvs   = dtda_pkg::DIVISOR_YEAR;
				recip = dtda_pkg::RECIP_YEAR;
			end
			dtda_pkg::DIV_S60: begin
				op    = dsec_mag;
				dvs   = dtda_pkg::DIVISOR_60;
				recip = dtda_pkg::RECIP_60;
			end
			dtda_pkg::DIV_M60: begin
				op    = dvd_q;
				dvs   = dtda_pkg::DIVISOR_60;
				recip = dtda_pkg::RECIP_60;
			end
			dtda_pkg::DIV_H24: begin
				op    = dvd_q;
				dvs   = dtda_pkg::DIVISOR_24;
				recip = dtda_pkg::RECIP_24;
			end
			default: begin
				op    = dvd_q;
				dvs   = dtda_pkg::DIVISOR_60;
				recip = dtda_pkg::RECIP_60;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			cnt_q     <= '0;
		end else if (cmd.div_start) begin
			div_run_q <= 1'b1;
			cnt_q     <= '0;
		end else if (div_run_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd2) div_run_q <= 1'b0;
		end
	end

	// Month step: floor carry of the month sum into the year.
	logic signed [5:0]  rm;
	logic signed [5:0]  t_m;
	logic signed [5:0]  mon_nx;
	logic signed [2:0]  c_m;
	logic signed [33:0] ysum;
	logic signed [33:0] yq;

	always_comb begin
		rm  = dmon_q[31] ? -$signed({2'b0, mr_q}) : $signed({2'b0, mr_q});
		t_m = $signed({2'b0, month_q}) + rm - 6'sd1;
		if (t_m < 6'sd0) begin
			c_m = -3'sd1;
			mon_nx = t_m + 6'sd13;
		end else if (t_m >= 6'sd24) begin
			c_m = 3'sd2;
			mon_nx = t_m - 6'sd23;
		end else if (t_m >= 6'sd12) begin
			c_m = 3'sd1;
			mon_nx = t_m - 6'sd11;
		end else begin
			c_m = 3'sd0;
			mon_nx = t_m + 6'sd1;
		end
		yq   = dmon_q[31] ? -$signed({2'b0, mq_q}) : $signed({2'b0, mq_q});
		ysum = 34'(year_q) + yq + 34'(c_m);
	end

	// Nanosecond step.
	logic signed [32:0] t_n;
	logic signed [32:0] n_nx;
	logic signed [2:0]  c_n;

	always_comb begin
		t_n = $signed({3'b0, nano_q}) + 33'(dnano_q);
		if (t_n < -dtda_pkg::NS_PER_S) begin
			c_n  = -3'sd2;
			n_nx = t_n + dtda_pkg::NS_TWO_S;
		end else if (t_n < 33'sd0) begin
			c_n  = -3'sd1;
			n_nx = t_n + dtda_pkg::NS_PER_S;
		end else if (t_n >= dtda_pkg::NS_TWO_S) begin
			c_n  = 3'sd2;
			n_nx = t_n - dtda_pkg::NS_TWO_S;
		end else if (t_n >= dtda_pkg::NS_PER_S) begin
			c_n  = 3'sd1;
			n_nx = t_n - dtda_pkg::NS_PER_S;
		end else begin
			c_n  = 3'sd0;
			n_nx = t_n;
		end
	end

	// Second, minute, hour and day sums, each but the day sum with a floor carry.
	logic signed [7:0]  srs, mrs, hrs;
	logic signed [7:0]  t_s, t_mi, t_h;
	logic signed [7:0]  s_nx, mi_nx, h_nx;
	logic signed [2:0]  c_s, c_mi, c_h;
	logic signed [17:0] dys;
	logic signed [17:0] d_nx;

	always_comb begin
		srs = dsec_q[31] ? -$signed({2'b0, sr_q})   : $signed({2'b0, sr_q});
		mrs = dsec_q[31] ? -$signed({2'b0, minr_q}) : $signed({2'b0, minr_q});
		hrs = dsec_q[31] ? -$signed({3'b0, hr_q})   : $signed({3'b0, hr_q});
		dys = dsec_q[31] ? -$signed({3'b0, days_q}) : $signed({3'b0, days_q});

		t_s = $signed({2'b0, second_q}) + srs + 8'(nc_q);
		if (t_s < -8'sd60) begin
			c_s = -3'sd2; s_nx = t_s + 8'sd120;
		end else if (t_s < 8'sd0) begin
			c_s = -3'sd1; s_nx = t_s + 8'sd60;
		end else if (t_s >= 8'sd120) begin
			c_s = 3'sd2;  s_nx = t_s - 8'sd120;
		end else if (t_s >= 8'sd60) begin
			c_s = 3'sd1;  s_nx = t_s - 8'sd60;
		end else begin
			c_s = 3'sd0;  s_nx = t_s;
		end

		t_mi = $signed({2'b0, minute_q}) + mrs + 8'(c_s);
		if (t_mi < -8'sd60) begin
			c_mi = -3'sd2; mi_nx = t_mi + 8'sd120;
		end else if (t_mi < 8'sd0) begin
			c_mi = -3'sd1; mi_nx = t_mi + 8'sd60;
		end else if (t_mi >= 8'sd120) begin
			c_mi = 3'sd2;  mi_nx = t_mi - 8'sd120;
		end else if (t_mi >= 8'sd60) begin
			c_mi = 3'sd1;  mi_nx = t_mi - 8'sd60;
		end else begin
			c_mi = 3'sd0;  mi_nx = t_mi;
		end

		t_h = $signed({3'b0, hour_q}) + hrs + 8'(c_mi);
		if (t_h < -8'sd24) begin
			c_h = -3'sd2; h_nx = t_h + 8'sd48;
		end else if (t_h < 8'sd0) begin
			c_h = -3'sd1; h_nx = t_h + 8'sd24;
		end else if (t_h >= 8'sd48) begin
			c_h = 3'sd2;  h_nx = t_h - 8'sd48;
		end else if (t_h >= 8'sd24) begin
			c_h = 3'sd1;  h_nx = t_h - 8'sd24;
		end else begin
			c_h = 3'sd0;  h_nx = t_h;
		end

		d_nx = day_q + dys + 18'(c_h);
	end

	// Month walk: one month per cycle. The year mod 400 is tracked alongside the year.
	logic              leap;
	logic [4:0]        md_cur;
	logic [4:0]        md_prev;
	logic              day_low;
	logic              day_high;

	always_comb begin
		leap = (ymod_q[1:0] == 2'b00) && (ymod_q != 9'd100) &&
		       (ymod_q != 9'd200) && (ymod_q != 9'd300);
		md_cur   = dtda_pkg::month_length(month_q, leap);
		md_prev  = (month_q == dtda_pkg::MONTH_JAN) ? 5'd31 :
		           dtda_pkg::month_length(month_q - 4'd1, leap);
		day_low  = (day_q < 18'sd1);
		day_high = (day_q > $signed({13'b0, md_cur}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= dtda_pkg::RS_NORMAL;
		end else if (cmd.load) begin
			sat_q <= dtda_pkg::RS_NORMAL;
		end else if (cmd.mon_step) begin
			if (ysum > dtda_pkg::YEAR_MAX) sat_q <= dtda_pkg::RS_FUTURE;
			else if (ysum < dtda_pkg::YEAR_MIN) sat_q <= dtda_pkg::RS_PAST;
		end else if (cmd.walk_step) begin
			if (day_low && month_q == dtda_pkg::MONTH_JAN && year_q == dtda_pkg::YEAR_MIN16)
				sat_q <= dtda_pkg::RS_PAST;
			else if (!day_low && day_high && month_q == dtda_pkg::MONTH_DEC &&
			         year_q == dtda_pkg::YEAR_MAX16)
				sat_q <= dtda_pkg::RS_FUTURE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q   <= op;
			dvs_q   <= dvs;
			recip_q <= recip;
			sel_q   <= cmd.div_sel;
		end else if (div_run_q) begin
			if (cnt_q == 2'd0) prod_q <= 64'(dvd_q) * 64'(recip_q);
			if (cnt_q == 2'd1) begin
				quo_q <= prod_q[63:32];
				rem_q <= rem_wide[9:0];
			end
			// The quotient stays in the dividend register for the next division of a chain.
			if (div_last) dvd_q <= quo_nx;
		end
		if (div_last) begin
			case (sel_q)
				dtda_pkg::DIV_MON: begin
					mq_q <= quo_nx;
					mr_q <= rem_nx[3:0];
				end
				dtda_pkg::DIV_YEAR: begin
					ymod_q <= (year_q[15] && rem_nx != 9'd0) ?
					          9'(dtda_pkg::DIVISOR_YEAR - rem_nx) : rem_nx;
				end
				dtda_pkg::DIV_S60: sr_q <= rem_nx[5:0];
				dtda_pkg::DIV_M60: minr_q <= rem_nx[5:0];
				dtda_pkg::DIV_H24: begin
					hr_q   <= rem_nx[4:0];
					days_q <= quo_nx[14:0];
				end
				default: begin
				end
			endcase
		end

		if (cmd.load) begin
			year_q   <= start_year;
			month_q  <= start_month;
			day_q    <= {13'b0, start_day};
			utc_q    <= start_utc;
			hour_q   <= start_hour;
			minute_q <= start_minute;
			second_q <= start_second;
			nano_q   <= start_nanosecond;
			dmon_q   <= add_months;
			dsec_q   <= add_seconds;
			dnano_q  <= add_nanoseconds;
		end else if (cmd.mon_step) begin
			year_q  <= ysum[15:0];
			month_q <= mon_nx[3:0];
		end else if (cmd.nano_step) begin
			nano_q <= n_nx[29:0];
			nc_q   <= c_n;
		end else if (cmd.clock_step) begin
			second_q <= s_nx[5:0];
			minute_q <= mi_nx[5:0];
			hour_q   <= h_nx[4:0];
			day_q    <= d_nx;
		end else if (cmd.walk_step) begin
			if (day_low) begin
				if (month_q == dtda_pkg::MONTH_JAN) begin
					if (year_q != dtda_pkg::YEAR_MIN16) begin
						year_q  <= year_q - 16'sd1;
						ymod_q  <= (ymod_q == 9'd0) ? 9'd399 : ymod_q - 9'd1;
						month_q <= dtda_pkg::MONTH_DEC;
						day_q   <= day_q + 18'sd31;
					end
				end else begin
					month_q <= month_q - 4'd1;
					day_q   <= day_q + $signed({13'b0, md_prev});
				end
			end else if (day_high) begin
				if (month_q == dtda_pkg::MONTH_DEC) begin
					if (year_q != dtda_pkg::YEAR_MAX16) begin
						year_q  <= year_q + 16'sd1;
						ymod_q  <= (ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1;
						month_q <= dtda_pkg::MONTH_JAN;
						day_q   <= day_q - $signed({13'b0, md_cur});
					end
				end else begin
					month_q <= month_q + 4'd1;
					day_q   <= day_q - $signed({13'b0, md_cur});
				end
			end
		end
	end

	assign stat.div_run  = div_run_q;
	assign stat.div_done = div_last;
	assign stat.sat      = (sat_q != dtda_pkg::RS_NORMAL);
	assign stat.walk_ok  = !day_low && !day_high;

	always_comb begin
		end_utc      = utc_q;
		range_status = sat_q;
		case (sat_q)
			dtda_pkg::RS_FUTURE: begin
				end_year       = dtda_pkg::YEAR_MAX16;
				end_month      = 8'hFF;
				end_day        = 8'hFF;
				end_hour       = 8'hFF;
				end_minute     = 8'hFF;
				end_second     = 8'hFF;
				end_nanosecond = 32'hFFFF_FFFF;
			end
			dtda_pkg::RS_PAST: begin
				end_year       = dtda_pkg::YEAR_MIN16;
				end_month      = 8'h00;
				end_day        = 8'h00;
				end_hour       = 8'h00;
				end_minute     = 8'h00;
				end_second     = 8'h00;
				end_nanosecond = 32'h0;
			end
			default: begin
				end_year       = year_q;
				end_month      = {4'b0, month_q};
				end_day        = day_q[7:0];
				end_hour       = {3'b0, hour_q};
				end_minute     = {2'b0, minute_q};
				end_second     = {2'b0, second_q};
				end_nanosecond = {2'b0, nano_q};
			end
		endcase
	end

endmodule

>>> design/date_time_duration_adder.sv
// Top level of the date-time duration adder: joins the sequencer and the datapath.
// Depends on dtda_pkg, dtda_ctrl and dtda_dpath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  input     | start, busy        | start_* date-time fields, add_* duration
//  result    | done (one cycle)   | end_* date-time fields, range_status
//
// done follows the month division, the month step, the year division, the second, minute and hour
// divisions, the nanosecond and clock steps and the day normalization, one month per cycle.
// All five divisions are passes of the shared divider.
// A year overflow in the month step raises done without the remaining divisions and steps.
// busy rises at the accepting edge and falls at the edge that ends the done cycle.
// Reset clears the sequencer and status; the result ports cannot be stalled.
module date_time_duration_adder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic signed [15:0] start_year,
	input  logic [3:0]         start_month,
	input  logic [4:0]         start_day,
	input  logic               start_utc,
	input  logic [4:0]         start_hour,
	input  logic [5:0]         start_minute,
	input  logic [5:0]         start_second,
	input  logic [29:0]        start_nanosecond,
	input  logic signed [31:0] add_months,
	input  logic signed [31:0] add_seconds,
	input  logic signed [30:0] add_nanoseconds,
	output logic signed [15:0] end_year,
	output logic [7:0]         end_month,
	output logic [7:0]         end_day,
	output logic               end_utc,
	output logic [7:0]         end_hour,
	output logic [7:0]         end_minute,
	output logic [7:0]         end_second,
	output logic [31:0]        end_nanosecond,
	output logic [1:0]         range_status
);

	dtda_pkg::dtda_cmd_t  cmd;
	dtda_pkg::dtda_stat_t stat;

	dtda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dtda_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.start_year       (start_year),
		.start_month      (start_month),
		.start_day        (start_day),
		.start_utc        (start_utc),
		.start_hour       (start_hour),
		.start_minute     (start_minute),
		.start_second     (start_second),
		.start_nanosecond (start_nanosecond),
		.add_months       (add_months),
		.add_seconds      (add_seconds),
		.add_nanoseconds  (add_nanoseconds),
		.end_year         (end_year),
		.end_month        (end_month),
		.end_day          (end_day),
		.end_utc          (end_utc),
		.end_hour         (end_hour),
		.end_minute       (end_minute),
		.end_second       (end_second),
		.end_nanosecond   (end_nanosecond),
		.range_status     (range_status)
	);

endmodule

>>> design/dtda_checker.sv
// Port-level checks of the date-time duration adder, bound to the top level.
// Depends on date_time_duration_adder and dtda_pkg.
module dtda_props (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] end_year,
	input logic [7:0]         end_month,
	input logic [1:0]         range_status
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("done outside a busy window or busy held after it");

	a_future_year: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_status == dtda_pkg::RS_FUTURE |-> end_year == 16'sh7FFF)
		else $error("future saturation with wrong year");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_status == dtda_pkg::RS_NORMAL |-> end_month >= 8'd1 && end_month <= 8'd12)
		else $error("normal result with month out of range");

endmodule

bind date_time_duration_adder dtda_props u_dtda_props (.*);

>>> tb/dtda_checker.sv
// Checker for the date-time duration adder: watches accepted transactions and results,
// predicts each sum from the start value and duration, and counts mismatches.
// Depends on dtda_pkg for the range status codes.
module dtda_checker (
	input  logic               clk,
	input  logic               start,
	input  logic               busy,
	input  logic               done,
	input  logic signed [15:0] start_year,
	input  logic [3:0]         start_month,
	input  logic [4:0]         start_day,
	input  logic               start_utc,
	input  logic [4:0]         start_hour,
	input  logic [5:0]         start_minute,
	input  logic [5:0]         start_second,
	input  logic [29:0]        start_nanosecond,
	input  logic signed [31:0] add_months,
	input  logic signed [31:0] add_seconds,
	input  logic signed [30:0] add_nanoseconds,
	input  logic signed [15:0] end_year,
	input  logic [7:0]         end_month,
	input  logic [7:0]         end_day,
	input  logic               end_utc,
	input  logic [7:0]         end_hour,
	input  logic [7:0]         end_minute,
	input  logic [7:0]         end_second,
	input  logic [31:0]        end_nanosecond,
	input  logic [1:0]         range_status,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic        utc;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [31:0] nano;
		logic [1:0]  status;
	} sum_t;

	sum_t sums_due[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if (a % b < 0)
			q--;
		return q;
	endfunction

	function automatic longint mdays(longint y, longint m);
		bit leap;
		leap = (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
		if (m == 2)
			return leap ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic sum_t saturated(bit future, logic utc);
		sum_t s;
		s.year   = future ? 16'h7FFF : 16'h8000;
		s.month  = future ? 8'hFF : 8'h00;
		s.day    = s.month;
		s.hour   = s.month;
		s.minute = s.month;
		s.second = s.month;
		s.nano   = future ? 32'hFFFF_FFFF : 32'h0;
		s.utc    = utc;
		s.status = future ? dtda_pkg::RS_FUTURE : dtda_pkg::RS_PAST;
		return s;
	endfunction

	function automatic sum_t add_duration();
		longint yr, mo, dy, hr, mi, se, ns, dm, ds, t, c;
		sum_t s;
		yr = start_year; mo = start_month; dy = start_day; hr = start_hour;
		mi = start_minute; se = start_second; ns = start_nanosecond;
		dm = add_months; ds = add_seconds;
		t = mo + dm % 12 - 1;
		c = fdiv(t, 12);
		mo = t - 12 * c + 1;
		yr = yr + dm / 12 + c;
		if (yr > 32767)
			return saturated(1, start_utc);
		if (yr < -32768)
			return saturated(0, start_utc);
		t = ns + longint'(add_nanoseconds);
		c = fdiv(t, 1000000000);
		ns = t - c * 1000000000;
		t = se + ds % 60 + c;
		c = fdiv(t, 60);
		se = t - c * 60;
		t = mi + ds / 60 % 60 + c;
		c = fdiv(t, 60);
		mi = t - c * 60;
		t = hr + ds / 3600 % 24 + c;
		c = fdiv(t, 24);
		hr = t - c * 24;
		dy = dy + ds / 86400 + c;
		while (dy < 1 || dy > mdays(yr, mo)) begin
			if (dy < 1) begin
				mo--;
				if (mo == 0) begin
					if (yr == -32768)
						return saturated(0, start_utc);
					yr--;
					mo = 12;
				end
				dy += mdays(yr, mo);
			end else begin
				dy -= mdays(yr, mo);
				mo++;
				if (mo > 12) begin
					if (yr == 32767)
						return saturated(1, start_utc);
					yr++;
					mo = 1;
				end
			end
		end
		s.year = yr[15:0]; s.month = mo[7:0]; s.day = dy[7:0]; s.utc = start_utc;
		s.hour = hr[7:0]; s.minute = mi[7:0]; s.second = se[7:0]; s.nano = ns[31:0];
		s.status = dtda_pkg::RS_NORMAL;
		return s;
	endfunction

	always @(posedge clk) begin
		sum_t e;
		if (start && !busy)
			sums_due.push_back(add_duration());
		if (done) begin
			if (sums_due.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				e = sums_due.pop_front();
				if (end_year !== e.year) begin
					$error("end_year exp %0h got %0h", e.year, end_year); errors++;
				end
				if (end_month !== e.month) begin
					$error("end_month exp %0d got %0d", e.month, end_month); errors++;
				end
				if (end_day !== e.day) begin
					$error("end_day exp %0d got %0d", e.day, end_day); errors++;
				end
				if (end_utc !== e.utc) begin
					$error("end_utc exp %0d got %0d", e.utc, end_utc); errors++;
				end
				if (end_hour !== e.hour) begin
					$error("end_hour exp %0d got %0d", e.hour, end_hour); errors++;
				end
				if (end_minute !== e.minute) begin
					$error("end_minute exp %0d got %0d", e.minute, end_minute); errors++;
				end
				if (end_second !== e.second) begin
					$error("end_second exp %0d got %0d", e.second, end_second); errors++;
				end
				if (end_nanosecond !== e.nano) begin
					$error("end_nanosecond exp %0d got %0d", e.nano, end_nanosecond);
					errors++;
				end
				if (range_status !== e.status) begin
					$error("range_status exp %0d got %0d", e.status, range_status); errors++;
				end
			end
		end
		pending = sums_due.size();
	end
endmodule

>>> tb/tb_date_time_duration_adder.sv
// Testbench top for the date-time duration adder: clock, reset, directed and random
// stimulus, and the verdict. Depends on dtda_pkg, the block and dtda_checker.
module tb_date_time_duration_adder;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0, arst_n = 0, start = 0;
	logic               busy, done;
	logic signed [15:0] start_year = 0;
	logic [3:0]         start_month = 1;
	logic [4:0]         start_day = 1;
	logic               start_utc = 0;
	logic [4:0]         start_hour = 0;
	logic [5:0]         start_minute = 0, start_second = 0;
	logic [29:0]        start_nanosecond = 0;
	logic signed [31:0] add_months = 0, add_seconds = 0;
	logic signed [30:0] add_nanoseconds = 0;
	logic signed [15:0] end_year;
	logic [7:0]         end_month, end_day, end_hour, end_minute, end_second;
	logic               end_utc;
	logic [31:0]        end_nanosecond;
	logic [1:0]         range_status;
	int                 errors, pending;

	always #6 clk = ~clk;

	date_time_duration_adder DUT (.*);
	dtda_checker checker_i (.*);

	// Random gap, mostly short with the odd long one.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
		repeat (n) @(negedge clk);
	endtask

	// Presents one transaction and holds it until the block takes it.
	task automatic send_sum(logic signed [15:0] y, logic [3:0] mo, logic [4:0] d, logic u,
			logic [4:0] h, logic [5:0] mi, logic [5:0] s, logic [29:0] ns,
			logic signed [31:0] dm, logic signed [31:0] ds, logic signed [30:0] dn);
		start_year = y; start_month = mo; start_day = d; start_utc = u;
		start_hour = h; start_minute = mi; start_second = s; start_nanosecond = ns;
		add_months = dm; add_seconds = ds; add_nanoseconds = dn;
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
		idle_gap();
	endtask

	task automatic send_random();
		logic signed [31:0] dm, ds;
		logic signed [30:0] dn;
		int k;
		k = $urandom_range(0, 9);
		dm = (k < 2) ? $urandom : $signed($urandom_range(0, 4000)) - 2000;
		ds = (k < 5) ? $urandom : $signed($urandom_range(0, 20000000)) - 10000000;
		dn = 31'($signed($urandom_range(0, 1999999998)) - 999999999);
		if (k == 9)
			dn = 31'($urandom);
		if (k == 8)
			send_sum(16'($urandom), 4'($urandom), 5'($urandom), 1'($urandom),
				5'($urandom), 6'($urandom), 6'($urandom), 30'($urandom), dm, ds, dn);
		else
			send_sum(16'($urandom), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)),
				1'($urandom), 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
				6'($urandom_range(0, 59)), 30'($urandom_range(0, 999999999)), dm, ds, dn);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_sum(0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		send_sum(2000, 2, 28, 1, 23, 59, 59, 999999999, 0, 86400, 1);
		send_sum(1900, 2, 28, 0, 0, 0, 0, 0, 0, 86400, 0);
		send_sum(2024, 3, 1, 1, 0, 0, 0, 0, 0, -1, 0);
		send_sum(1, 1, 1, 0, 0, 0, 0, 0, -12, 0, -1000000000);
		send_sum(32767, 12, 31, 1, 23, 59, 59, 999999999, 0, 0, 1);
		send_sum(-32768, 1, 1, 0, 0, 0, 0, 0, 0, 0, -1);
		send_sum(32767, 12, 1, 0, 0, 0, 0, 0, 1, 0, 0);
		send_sum(-32768, 1, 1, 1, 0, 0, 0, 0, -1, 0, 0);
		send_sum(0, 6, 15, 0, 12, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
		send_sum(0, 6, 15, 1, 12, 0, 0, 0, 32'h8000_0000, 0, 0);
		send_sum(0, 6, 15, 0, 12, 30, 30, 500, 0, 32'h7FFF_FFFF, 999999999);
		send_sum(0, 6, 15, 1, 12, 30, 30, 500, 0, 32'h8000_0000, -999999999);
		send_sum(100, 0, 0, 0, 31, 63, 63, 30'h3FFF_FFFF, 0, 0, 0);
		send_sum(100, 15, 31, 1, 0, 0, 0, 0, 0, 0, 0);
		send_sum(5, 4, 31, 0, 0, 0, 0, 0, 0, -86400, 0);
		send_sum(5, 4, 1, 1, 0, 0, 0, 0, -24, -3600, 0);
		send_sum(5, 4, 1, 0, 1, 1, 1, 1, 0, -3661, -1);
		send_sum(400, 2, 29, 1, 0, 0, 0, 0, 12, 0, 0);
		send_sum(0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 31'h4000_0000);
		repeat (660) send_random();
		fork
			wait (pending == 0);
			begin
				repeat (2000000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (1200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> sim.f
design/dtda_pkg.sv
design/dtda_ctrl.sv
design/dtda_dpath.sv
design/date_time_duration_adder.sv
design/dtda_checker.sv
tb/dtda_checker.sv
tb/tb_date_time_duration_adder.sv
